// ===== rtl/cfpt_pkg.sv =====
// Shared constants, types and the arctangent table for the camera frame tracker.
package cfpt_pkg;

   localparam int DIST_LIMIT_PX = 200;
   localparam int CORDIC_STEPS  = 16;
   localparam int SQRT_STEPS    = 12;
   localparam int DIV_STEPS     = 18;
   localparam int FIFO_DEPTH    = 2;
   // The root loop needs one warm-up step beside its digits, so the shared
   // iteration runs long enough for whichever of the two needs more.
   localparam int ITER_STEPS    = (CORDIC_STEPS > SQRT_STEPS) ? CORDIC_STEPS
                                                              : SQRT_STEPS + 1;

   localparam logic [7:0]  HDR_BYTE      = 8'd255;
   localparam logic [11:0] DIST_LIMIT    = 12'(DIST_LIMIT_PX * 16);
   localparam logic [14:0] ANG_225       = 15'd14400;
   localparam logic [14:0] FULL_TURN     = 15'd23040;
   localparam logic [14:0] HALF_TURN     = 15'd11520;
   localparam logic [12:0] QUARTER_TURN  = 13'd5760;
   localparam logic [12:0] EIGHTH_TURN   = 13'd2880;
   localparam logic [17:0] STRENGTH_NUM  = 18'd160000;
   localparam logic [17:0] STRENGTH_OFS  = 18'd100;
   localparam logic [17:0] STRENGTH_MIN  = 18'd101;
   localparam logic signed [25:0] Z_MAX  = 26'sd5898240;

   // Frame position codes of the header hunt.
   localparam logic [2:0] POS_HUNT  = 3'd0;
   localparam logic [2:0] POS_HDR   = 3'd1;
   localparam logic [2:0] POS_FIRST = 3'd2;
   localparam logic [2:0] POS_LAST  = 3'd7;

   // Six coordinate bytes: yellow x,y, blue x,y, ball x,y (byte 0 lowest).
   typedef logic [47:0] frame_type;

   typedef struct packed {
      logic      valid;
      frame_type data;
   } push_type;

   typedef enum logic [2:0] {
      B_IDLE, B_PREP, B_SUM, B_ITER, B_FIN, B_DIV, B_OUT
   } back_state_type;

   function automatic logic [22:0] atan_entry(input logic [4:0] i);
      logic [22:0] r;
      unique case (i)
         5'd0:  r = 23'd2949120;
         5'd1:  r = 23'd1740967;
         5'd2:  r = 23'd919879;
         5'd3:  r = 23'd466945;
         5'd4:  r = 23'd234379;
         5'd5:  r = 23'd117304;
         5'd6:  r = 23'd58666;
         5'd7:  r = 23'd29335;
         5'd8:  r = 23'd14668;
         5'd9:  r = 23'd7334;
         5'd10: r = 23'd3667;
         5'd11: r = 23'd1833;
         5'd12: r = 23'd917;
         5'd13: r = 23'd458;
         5'd14: r = 23'd229;
         5'd15: r = 23'd115;
         5'd16: r = 23'd57;
         5'd17: r = 23'd29;
         5'd18: r = 23'd14;
         5'd19: r = 23'd7;
         5'd20: r = 23'd4;
         5'd21: r = 23'd2;
         5'd22: r = 23'd1;
         default: r = 23'd0;
      endcase
      return r;
   endfunction

endpackage

// ===== rtl/cfpt_front.sv =====
// Front end: header hunt and collection of the six coordinate bytes of a frame.
module cfpt_front (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  logic [7:0]          req_rx_byte,
   input  logic                fifo_full,
   output cfpt_pkg::push_type  push
);
   import cfpt_pkg::*;

   logic [2:0]  pos_ff, pos_in;
   logic [7:0]  coord_ff [5];
   logic        take;

   // Stalling on a full queue is conservative but keeps the front trivial.
   assign req_stall = fifo_full;
   assign take      = req_valid && !fifo_full;

   always_comb begin
      pos_in = pos_ff;
      if (take) begin
         priority if (pos_ff == POS_HUNT) begin
            pos_in = (req_rx_byte == HDR_BYTE) ? POS_HDR : POS_HUNT;
         end else if (pos_ff == POS_HDR) begin
            pos_in = (req_rx_byte == HDR_BYTE) ? POS_FIRST : POS_HUNT;
         end else if (pos_ff == POS_LAST) begin
            pos_in = POS_HUNT;
         end else begin
            pos_in = pos_ff + 3'd1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= POS_HUNT;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take && pos_ff >= POS_FIRST && pos_ff != POS_LAST) begin
         coord_ff[pos_ff - POS_FIRST] <= req_rx_byte;
      end
   end

   assign push.valid = take && (pos_ff == POS_LAST);
   assign push.data  = {req_rx_byte, coord_ff[4], coord_ff[3], coord_ff[2],
                        coord_ff[1], coord_ff[0]};

endmodule

// ===== rtl/cfpt_fifo.sv =====
// Short queue of complete frames between the front end and the solver.
module cfpt_fifo (
   input  logic                clock,
   input  logic                reset,
   input  cfpt_pkg::push_type  push,
   output logic                full,
   input  logic                pop,
   output logic                empty,
   output cfpt_pkg::frame_type pop_data
);
   import cfpt_pkg::*;

   frame_type  mem_ff [FIFO_DEPTH];
   logic [$clog2(FIFO_DEPTH)-1:0] wr_ff, rd_ff;
   logic [$clog2(FIFO_DEPTH):0]   cnt_ff;
   logic       do_push, do_pop;

   assign full     = (cnt_ff == ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH));
   assign empty    = (cnt_ff == '0);
   assign do_push  = push.valid && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ff];

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push.data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         if (do_push) wr_ff <= wr_ff + 1'b1;
         if (do_pop)  rd_ff <= rd_ff + 1'b1;
         cnt_ff <= cnt_ff + (do_push ? 1'b1 : 1'b0) - (do_pop ? 1'b1 : 1'b0);
      end
   end

   assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= ($clog2(FIFO_DEPTH)+1)'(FIFO_DEPTH))
      else $error("frame queue count overflow");
   assert property (@(posedge clock) disable iff (reset)
      (full && !do_pop) |=> full)
      else $error("frame queue lost a word");
   assert property (@(posedge clock) disable iff (reset)
      (empty && !push.valid) |=> empty)
      else $error("frame queue invented a word");

endmodule

// ===== rtl/cfpt_back.sv =====
// Solver: per object square root and CORDIC angle, hold logic, strength divide.
module cfpt_back (
   input  logic                clock,
   input  logic                reset,
   input  logic                attack_blue,
   input  logic                fifo_empty,
   input  cfpt_pkg::frame_type fifo_data,
   output logic                fifo_pop,
   output logic                rsp_valid,
   input  logic                rsp_stall,
   output logic [14:0]         rsp_attack_angle,
   output logic [11:0]         rsp_attack_dist,
   output logic [14:0]         rsp_defend_angle,
   output logic [11:0]         rsp_defend_dist,
   output logic [14:0]         rsp_ball_dir_ccw,
   output logic [14:0]         rsp_ball_dir_raw,
   output logic [11:0]         rsp_ball_dist,
   output logic [13:0]         rsp_ball_strength,
   output logic                rsp_attack_seen,
   output logic                rsp_defend_seen,
   output logic                rsp_ball_seen
);
   import cfpt_pkg::*;

   back_state_type state_ff, state_in;
   logic [1:0]  obj_ff;
   logic [4:0]  step_ff;
   frame_type   frame_ff;

   logic signed [8:0]  dx_ff, dy_ff;
   logic [7:0]         ax_ff, ay_ff;
   logic [14:0]        sqx_ff, sqy_ff;

   logic [23:0] sv_ff;
   logic [15:0] srem_ff;
   logic [11:0] root_ff;
   logic signed [35:0] cx_ff, cy_ff;
   logic signed [25:0] cz_ff;

   logic [14:0] held_ang_ff [3];
   logic [11:0] held_dist_ff [3];
   logic [14:0] ang_ff [3];
   logic [11:0] dist_ff [3];
   logic        seen_ff [3];
   logic [14:0] raw_ball_ff;

   logic [11:0] bd_ff;
   logic [12:0] drem_ff;
   logic [17:0] quo_ff;
   logic        out_free;

   logic [7:0]  sel_x, sel_y;
   logic signed [8:0] dx_c, dy_c;
   logic [15:0] strial, sshift;
   logic signed [35:0] cxs, cys;
   logic signed [25:0] zc;
   logic [12:0] t_c;
   logic [14:0] a_q, a_fin, a_raw, a_use;
   logic [11:0] d_use;
   logic [12:0] dshift;
   logic [17:0] strength;

   assign out_free = !rsp_valid || !rsp_stall;
   assign fifo_pop = (state_ff == B_IDLE) && !fifo_empty;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         B_IDLE: if (!fifo_empty) state_in = B_PREP;
         B_PREP: state_in = B_SUM;
         B_SUM:  state_in = B_ITER;
         B_ITER: if (step_ff == 5'(ITER_STEPS - 1)) state_in = B_FIN;
         B_FIN:  state_in = (obj_ff == 2'd2) ? B_DIV : B_PREP;
         B_DIV:  if (step_ff == 5'(DIV_STEPS - 1)) state_in = B_OUT;
         B_OUT:  if (out_free) state_in = B_IDLE;
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= B_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // Offsets from image center for the current object.
   always_comb begin
      sel_x = frame_ff[{obj_ff, 1'b0, 3'd0} +: 8];
      sel_y = frame_ff[{obj_ff, 1'b1, 3'd0} +: 8];
      dx_c  = 9'sd160 - $signed({1'b0, sel_x});
      dy_c  = 9'sd120 - $signed({1'b0, sel_y});
   end

   // One CORDIC step, one root digit and one quotient bit per cycle.
   always_comb begin
      cxs    = cx_ff >>> step_ff;
      cys    = cy_ff >>> step_ff;
      sshift = {srem_ff[13:0], sv_ff[23:22]};
      strial = {2'b00, root_ff, 2'b01};
      dshift = {drem_ff[11:0], STRENGTH_NUM[5'(DIV_STEPS - 1) - step_ff]};
   end

   // Angle assembly and hold for the finished object, and the ball strength from the quotient.
   always_comb begin
      if (cz_ff < 0) zc = '0;
      else if (cz_ff > Z_MAX) zc = Z_MAX;
      else zc = cz_ff;
      if (ay_ff == 8'd0) t_c = '0;
      else if (ax_ff == 8'd0) t_c = QUARTER_TURN;
      else if (ax_ff == ay_ff) t_c = EIGHTH_TURN;
      else t_c = 13'((zc + 26'sd512) >>> 10);
      priority if (dx_ff >= 0 && dy_ff >= 0) a_q = {2'b00, t_c};
      else if (dx_ff < 0 && dy_ff >= 0) a_q = HALF_TURN - {2'b00, t_c};
      else if (dx_ff < 0) a_q = HALF_TURN + {2'b00, t_c};
      else a_q = FULL_TURN - {2'b00, t_c};
      a_raw = (a_q >= FULL_TURN) ? a_q - FULL_TURN : a_q;
      if (obj_ff == 2'd2) a_fin = (a_raw == '0) ? '0 : FULL_TURN - a_raw;
      else a_fin = a_raw;
      a_use = (a_fin != ANG_225) ? a_fin : held_ang_ff[obj_ff];
      d_use = (root_ff < DIST_LIMIT) ? root_ff : held_dist_ff[obj_ff];
      if (bd_ff == '0) strength = '0;
      else if (quo_ff > STRENGTH_MIN) strength = quo_ff - STRENGTH_OFS;
      else strength = 18'd1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         obj_ff  <= '0;
         step_ff <= '0;
         for (int k = 0; k < 3; k++) begin
            held_ang_ff[k]  <= '0;
            held_dist_ff[k] <= '0;
         end
      end else begin
         unique case (state_ff)
            B_IDLE: begin
               obj_ff <= '0;
               if (!fifo_empty) frame_ff <= fifo_data;
            end
            B_PREP: begin
               dx_ff  <= dx_c;
               dy_ff  <= dy_c;
               ax_ff  <= 8'(dx_c < 0 ? -dx_c : dx_c);
               ay_ff  <= 8'(dy_c < 0 ? -dy_c : dy_c);
            end
            B_SUM: begin
               sqx_ff  <= 15'(ax_ff * ax_ff);
               sqy_ff  <= 15'(ay_ff * ay_ff);
               step_ff <= '0;
               srem_ff <= '0;
               root_ff <= '0;
               cx_ff   <= $signed({4'd0, ax_ff, 24'd0});
               cy_ff   <= $signed({4'd0, ay_ff, 24'd0});
               cz_ff   <= '0;
            end
            B_ITER: begin
               step_ff <= step_ff + 5'd1;
               if (step_ff == '0) begin
                  // Squares settle during the first step; load the root operand.
                  sv_ff <= {(16'({1'b0, sqx_ff}) + 16'({1'b0, sqy_ff})), 8'd0};
               end else if (step_ff <= 5'(SQRT_STEPS)) begin
                  sv_ff <= {sv_ff[21:0], 2'b00};
                  if (sshift >= strial) begin
                     srem_ff <= sshift - strial;
                     root_ff <= {root_ff[10:0], 1'b1};
                  end else begin
                     srem_ff <= sshift;
                     root_ff <= {root_ff[10:0], 1'b0};
                  end
               end
               if (step_ff < 5'(CORDIC_STEPS)) begin
                  if (cy_ff > 0) begin
                     cx_ff <= cx_ff + cys;
                     cy_ff <= cy_ff - cxs;
                     cz_ff <= cz_ff + $signed({3'd0, atan_entry(step_ff)});
                  end else if (cy_ff < 0) begin
                     cx_ff <= cx_ff - cys;
                     cy_ff <= cy_ff + cxs;
                     cz_ff <= cz_ff - $signed({3'd0, atan_entry(step_ff)});
                  end
               end
            end
            B_FIN: begin
               ang_ff[obj_ff]  <= a_use;
               dist_ff[obj_ff] <= d_use;
               seen_ff[obj_ff] <= (root_ff != '0);
               if (a_fin != ANG_225) held_ang_ff[obj_ff] <= a_fin;
               if (root_ff < DIST_LIMIT) held_dist_ff[obj_ff] <= root_ff;
               if (obj_ff == 2'd2) raw_ball_ff <= a_raw;
               if (obj_ff != 2'd2) obj_ff <= obj_ff + 2'd1;
               step_ff <= '0;
               bd_ff   <= d_use;
               drem_ff <= '0;
               quo_ff  <= '0;
            end
            B_DIV: begin
               step_ff <= step_ff + 5'd1;
               if (dshift >= {1'b0, bd_ff}) begin
                  drem_ff <= dshift - {1'b0, bd_ff};
                  quo_ff  <= {quo_ff[16:0], 1'b1};
               end else begin
                  drem_ff <= dshift;
                  quo_ff  <= {quo_ff[16:0], 1'b0};
               end
            end
            B_OUT: begin
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid <= 1'b0;
      end else if (state_ff == B_OUT && out_free) begin
         rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == B_OUT && out_free) begin
         rsp_attack_angle  <= attack_blue ? ang_ff[1] : ang_ff[0];
         rsp_attack_dist   <= attack_blue ? dist_ff[1] : dist_ff[0];
         rsp_attack_seen   <= attack_blue ? seen_ff[1] : seen_ff[0];
         rsp_defend_angle  <= attack_blue ? ang_ff[0] : ang_ff[1];
         rsp_defend_dist   <= attack_blue ? dist_ff[0] : dist_ff[1];
         rsp_defend_seen   <= attack_blue ? seen_ff[0] : seen_ff[1];
         rsp_ball_dir_ccw  <= ang_ff[2];
         rsp_ball_dir_raw  <= raw_ball_ff;
         rsp_ball_dist     <= dist_ff[2];
         rsp_ball_seen     <= seen_ff[2];
         rsp_ball_strength <= strength[13:0];
      end
   end

   assert property (@(posedge clock) disable iff (reset) obj_ff != 2'd3)
      else $error("object index out of range");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_ITER && step_ff == 5'(ITER_STEPS - 1)) |=> state_ff == B_FIN)
      else $error("iteration did not finish");
   assert property (@(posedge clock) disable iff (reset)
      held_dist_ff[0] < DIST_LIMIT && held_dist_ff[1] < DIST_LIMIT &&
      held_dist_ff[2] < DIST_LIMIT)
      else $error("held distance beyond limit");
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == B_OUT && out_free) |=> rsp_valid)
      else $error("result word not presented");

endmodule

// ===== rtl/camera_frame_polar_tracker.sv =====
// Each object passes through the PREP, SUM, ITER and FIN states of the shared CORDIC and root
// unit; the strength divide follows, and then the result word is registered.
// The solver takes a new frame from the queue only once it has registered the last result.
// Header and payload bytes are accepted one per cycle while the frame queue has room.
// Synchronous active-high reset clears the header hunt, the queue, held values and
// the attack_blue register; no clearing pass is needed.
module camera_frame_polar_tracker (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [7:0]  req_rx_byte,
   input  logic        csr_write_en,
   input  logic        csr_attack_blue,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [14:0] rsp_attack_angle,
   output logic [11:0] rsp_attack_dist,
   output logic [14:0] rsp_defend_angle,
   output logic [11:0] rsp_defend_dist,
   output logic [14:0] rsp_ball_dir_ccw,
   output logic [14:0] rsp_ball_dir_raw,
   output logic [11:0] rsp_ball_dist,
   output logic [13:0] rsp_ball_strength,
   output logic        rsp_attack_seen,
   output logic        rsp_defend_seen,
   output logic        rsp_ball_seen
);
   import cfpt_pkg::*;

   logic       attack_blue_ff;
   push_type   push;
   logic       fifo_full, fifo_empty, fifo_pop;
   frame_type  fifo_data;

   always_ff @(posedge clock) begin
      if (reset) begin
         attack_blue_ff <= 1'b0;
      end else if (csr_write_en) begin
         attack_blue_ff <= csr_attack_blue;
      end
   end

   cfpt_front u_front (
      .clock, .reset, .req_valid, .req_stall, .req_rx_byte,
      .fifo_full(fifo_full), .push(push)
   );

   cfpt_fifo u_fifo (
      .clock, .reset, .push(push), .full(fifo_full), .pop(fifo_pop),
      .empty(fifo_empty), .pop_data(fifo_data)
   );

   cfpt_back u_back (
      .clock, .reset, .attack_blue(attack_blue_ff), .fifo_empty(fifo_empty),
      .fifo_data(fifo_data), .fifo_pop(fifo_pop), .rsp_valid, .rsp_stall,
      .rsp_attack_angle, .rsp_attack_dist, .rsp_defend_angle, .rsp_defend_dist,
      .rsp_ball_dir_ccw, .rsp_ball_dir_raw, .rsp_ball_dist, .rsp_ball_strength,
      .rsp_attack_seen, .rsp_defend_seen, .rsp_ball_seen
   );

endmodule

// ===== tb/sv/tb.sv =====
// Self-checking testbench for the camera frame polar tracker.
module tb;
   import cfpt_pkg::*;

   typedef struct {
      logic [14:0] attack_angle;
      logic [11:0] attack_dist;
      logic [14:0] defend_angle;
      logic [11:0] defend_dist;
      logic [14:0] ball_dir_ccw;
      logic [14:0] ball_dir_raw;
      logic [11:0] ball_dist;
      logic [13:0] ball_strength;
      logic        attack_seen;
      logic        defend_seen;
      logic        ball_seen;
   } track_word_type;

   localparam int STALL_LIMIT = 3000;
   localparam int DRAIN_CYCLES = 120;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_stall;
   logic [7:0]  req_rx_byte = 8'd0;
   logic        csr_write_en = 1'b0;
   logic        csr_attack_blue = 1'b0;
   logic        rsp_valid;
   logic        rsp_stall = 1'b0;
   logic [14:0] rsp_attack_angle;
   logic [11:0] rsp_attack_dist;
   logic [14:0] rsp_defend_angle;
   logic [11:0] rsp_defend_dist;
   logic [14:0] rsp_ball_dir_ccw;
   logic [14:0] rsp_ball_dir_raw;
   logic [11:0] rsp_ball_dist;
   logic [13:0] rsp_ball_strength;
   logic        rsp_attack_seen;
   logic        rsp_defend_seen;
   logic        rsp_ball_seen;

   camera_frame_polar_tracker uut (.*);

   // Predictor state.
   track_word_type track_q[$];
   logic [2:0]  hunt_pos = POS_HUNT;
   logic [7:0]  coord[6];
   logic [14:0] kept_angle[3] = '{default: '0};
   logic [11:0] kept_dist[3] = '{default: '0};
   logic        attack_blue_model = 1'b0;

   int  send_idle_pct = 0;
   int  stall_pct = 0;
   int  hold_left = 0;
   bit  hold_go = 0;
   int  quiet_cycles = 0;
   bit  failed = 0;

   const longint arctan_deg[24] = '{2949120, 1740967, 919879, 466945, 234379, 117304,
      58666, 29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115,
      57, 29, 14, 7, 4, 2, 1, 0};

   initial forever #10 clock = ~clock;

   function automatic logic [14:0] first_quadrant(int ax, int ay);
      longint x, y, z, xs;
      x = longint'(ax) <<< 24;
      y = longint'(ay) <<< 24;
      z = 0;
      for (int i = 0; i < CORDIC_STEPS && i < 24; i++) begin
         xs = x >>> i;
         if (y > 0) begin
            x += y >>> i;
            y -= xs;
            z += arctan_deg[i];
         end else if (y < 0) begin
            x -= y >>> i;
            y += xs;
            z -= arctan_deg[i];
         end
      end
      if (z < 0) z = 0;
      if (z > 5898240) z = 5898240;
      return 15'((z + 512) >>> 10);
   endfunction

   function automatic logic [14:0] bearing(int dx, int dy);
      int ax, ay, t, a;
      ax = dx < 0 ? -dx : dx;
      ay = dy < 0 ? -dy : dy;
      if (ay == 0) t = 0;
      else if (ax == 0) t = 5760;
      else if (ax == ay) t = 2880;
      else t = first_quadrant(ax, ay);
      if (dx >= 0 && dy >= 0) a = t;
      else if (dx < 0 && dy >= 0) a = 11520 - t;
      else if (dx < 0) a = 11520 + t;
      else a = 23040 - t;
      if (a >= 23040) a -= 23040;
      return 15'(a);
   endfunction

   function automatic logic [11:0] range16(int dx, int dy);
      int unsigned v, r;
      v = (dx * dx + dy * dy) * 256;
      r = 0;
      for (int b = 15; b >= 0; b--)
         if ((r + (1 << b)) * (r + (1 << b)) <= v) r += (1 << b);
      return 12'(r);
   endfunction

   // Advances the header hunt by one byte and queues a word when a frame completes.
   task automatic track_byte(input logic [7:0] b);
      logic [14:0] ang[3];
      logic [11:0] dst[3];
      logic        seen[3];
      logic [14:0] raw_ball;
      int          dx, dy, q, atk, dfd;
      track_word_type w;
      if (hunt_pos == POS_HUNT) begin
         hunt_pos = (b == HDR_BYTE) ? POS_HDR : POS_HUNT;
         return;
      end
      if (hunt_pos == POS_HDR) begin
         hunt_pos = (b == HDR_BYTE) ? POS_FIRST : POS_HUNT;
         return;
      end
      coord[hunt_pos - POS_FIRST] = b;
      if (hunt_pos != POS_LAST) begin
         hunt_pos++;
         return;
      end
      hunt_pos = POS_HUNT;
      raw_ball = '0;
      for (int k = 0; k < 3; k++) begin
         dx = 160 - int'(coord[2 * k]);
         dy = 120 - int'(coord[2 * k + 1]);
         ang[k] = bearing(dx, dy);
         dst[k] = range16(dx, dy);
         if (k == 2) begin
            raw_ball = ang[k];
            ang[k] = (ang[k] == 0) ? 15'd0 : FULL_TURN - ang[k];
         end
         seen[k] = (dst[k] != 0);
         if (ang[k] != ANG_225) kept_angle[k] = ang[k];
         else ang[k] = kept_angle[k];
         if (dst[k] < DIST_LIMIT) kept_dist[k] = dst[k];
         else dst[k] = kept_dist[k];
      end
      q = (dst[2] != 0) ? 160000 / int'(dst[2]) : 0;
      atk = attack_blue_model ? 1 : 0;
      dfd = attack_blue_model ? 0 : 1;
      w.attack_angle  = ang[atk];
      w.attack_dist   = dst[atk];
      w.defend_angle  = ang[dfd];
      w.defend_dist   = dst[dfd];
      w.ball_dir_ccw  = ang[2];
      w.ball_dir_raw  = raw_ball;
      w.ball_dist     = dst[2];
      w.ball_strength = (dst[2] == 0) ? 14'd0 : (q > 101) ? 14'(q - 100) : 14'd1;
      w.attack_seen   = seen[atk];
      w.defend_seen   = seen[dfd];
      w.ball_seen     = seen[2];
      track_q.push_back(w);
   endtask

   task automatic send_byte(input logic [7:0] b);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_rx_byte <= b;
      do @(posedge clock); while (req_stall);
      track_byte(b);
   endtask

   task automatic send_frame(input logic [7:0] c[6]);
      send_byte(HDR_BYTE);
      send_byte(HDR_BYTE);
      for (int i = 0; i < 6; i++) send_byte(c[i]);
   endtask

   // Lets the block drain completely before a register write or a new phase.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (track_q.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic write_attack_blue(input logic v);
      wait_drained();
      csr_write_en    <= 1'b1;
      csr_attack_blue <= v;
      @(posedge clock);
      csr_write_en <= 1'b0;
      attack_blue_model = v;
   endtask

   task automatic random_objects(output logic [7:0] c[6]);
      int k;
      for (int o = 0; o < 3; o++) begin
         case ($urandom_range(9))
            0: begin // Diagonal offset, often the ambiguous 225 degree reading.
               k = $urandom_range(95);
               c[2 * o] = 8'(160 + k);
               c[2 * o + 1] = 8'(120 + k);
            end
            1: begin
               c[2 * o] = 8'd160;
               c[2 * o + 1] = 8'd120;
            end
            2: begin
               c[2 * o] = $urandom_range(1) ? 8'd0 : 8'd255;
               c[2 * o + 1] = $urandom_range(1) ? 8'd0 : 8'd255;
            end
            default: begin
               c[2 * o] = 8'($urandom_range(255));
               c[2 * o + 1] = 8'($urandom_range(255));
            end
         endcase
      end
   endtask

   task automatic random_traffic(input int frames);
      logic [7:0] c[6];
      for (int n = 0; n < frames; n++) begin
         case ($urandom_range(19))
            0: send_byte(8'($urandom_range(255)));
            1: begin // A lone header byte followed by a non-header byte.
               send_byte(HDR_BYTE);
               send_byte(8'($urandom_range(254)));
            end
            2: begin // A frame cut short, then another frame whose header is taken as payload.
               send_byte(HDR_BYTE);
               send_byte(HDR_BYTE);
               send_byte(8'($urandom_range(255)));
               random_objects(c);
               send_frame(c);
            end
            default: begin
               random_objects(c);
               send_frame(c);
            end
         endcase
      end
   endtask

   task automatic test_directed();
      send_idle_pct = 0;
      stall_pct = 0;
      write_attack_blue(1'b0);
      send_frame('{8'd160, 8'd120, 8'd160, 8'd120, 8'd160, 8'd120});
      send_frame('{8'd0, 8'd0, 8'd255, 8'd255, 8'd0, 8'd255});
      // Goals at exactly 225 degrees, ball direction at 225 after negation.
      send_frame('{8'd200, 8'd160, 8'd170, 8'd130, 8'd200, 8'd80});
      send_frame('{8'd100, 8'd50, 8'd160, 8'd30, 8'd255, 8'd120});
      // Header resync, and a payload byte of 255 taken as data.
      send_byte(HDR_BYTE);
      send_byte(8'd7);
      send_frame('{8'd255, 8'd255, 8'd10, 8'd200, 8'd150, 8'd110});
      write_attack_blue(1'b1);
      send_frame('{8'd1, 8'd2, 8'd254, 8'd253, 8'd161, 8'd121});
   endtask

   task automatic test_no_idling();
      send_idle_pct = 0;
      stall_pct = 0;
      random_traffic(30);
   endtask

   task automatic test_sender_idle();
      write_attack_blue(1'b0);
      send_idle_pct = 46;
      stall_pct = 0;
      random_traffic(30);
   endtask

   task automatic test_receiver_stall();
      send_idle_pct = 0;
      stall_pct = 46;
      random_traffic(30);
   endtask

   task automatic test_both_idle();
      write_attack_blue(1'b1);
      send_idle_pct = 36;
      stall_pct = 36;
      random_traffic(30);
   endtask

   // The receiver holds off while the sender keeps offering, so the input stalls.
   task automatic test_backpressure();
      send_idle_pct = 0;
      stall_pct = 0;
      hold_go = 1;
      random_traffic(8);
      wait_drained();
      random_traffic(4);
   endtask

   always @(posedge clock) begin
      if (hold_go) begin
         hold_go = 0;
         hold_left = 600;
      end
      if (hold_left > 0) hold_left--;
      rsp_stall <= (hold_left > 0) || ($urandom_range(99) < stall_pct);
   end

   task automatic compare_field(input string name, input int exp_v, input int act_v);
      if (exp_v != act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         failed = 1;
      end
   endtask

   always @(posedge clock) begin
      track_word_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (track_q.size() == 0) begin
            $display("%0t: unexpected result word", $time);
            failed = 1;
         end else begin
            w = track_q.pop_front();
            compare_field("attack_angle", w.attack_angle, rsp_attack_angle);
            compare_field("attack_dist", w.attack_dist, rsp_attack_dist);
            compare_field("defend_angle", w.defend_angle, rsp_defend_angle);
            compare_field("defend_dist", w.defend_dist, rsp_defend_dist);
            compare_field("ball_dir_ccw", w.ball_dir_ccw, rsp_ball_dir_ccw);
            compare_field("ball_dir_raw", w.ball_dir_raw, rsp_ball_dir_raw);
            compare_field("ball_dist", w.ball_dist, rsp_ball_dist);
            compare_field("ball_strength", w.ball_strength, rsp_ball_strength);
            compare_field("attack_seen", w.attack_seen, rsp_attack_seen);
            compare_field("defend_seen", w.defend_seen, rsp_defend_seen);
            compare_field("ball_seen", w.ball_seen, rsp_ball_seen);
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= STALL_LIMIT) begin
         $display("** camera_frame_polar_tracker: FAILED **");
         $finish;
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_no_idling();
      test_sender_idle();
      test_receiver_stall();
      test_both_idle();
      test_backpressure();
      wait_drained();
      if (!failed)
         $display("** camera_frame_polar_tracker: PASSED **");
      else
         $display("** camera_frame_polar_tracker: FAILED **");
      $finish;
   end

endmodule

// ===== sim.f =====
rtl/cfpt_pkg.sv
rtl/cfpt_front.sv
rtl/cfpt_fifo.sv
rtl/cfpt_back.sv
rtl/camera_frame_polar_tracker.sv
tb/sv/tb.sv
